// ===== src/nmsm_pkg.sv =====
// Package for the network-management mode machine.
// Holds mode and request codes, register indexes and the configuration struct.
// No dependencies; nmsm_csr, nmsm_core and the top level import it.
package nmsm_pkg;

   // Mode codes as seen on the result channel.
   localparam logic [2:0] MODE_INIT   = 3'd0;
   localparam logic [2:0] MODE_SLEEP  = 3'd1;
   localparam logic [2:0] MODE_PREP   = 3'd2;
   localparam logic [2:0] MODE_REPEAT = 3'd3;
   localparam logic [2:0] MODE_NORMAL = 3'd4;
   localparam logic [2:0] MODE_READY  = 3'd5;

   // Request kinds on the input channel.
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;

   // Timer run flag positions.
   localparam int unsigned RUN_TIMEOUT = 0;
   localparam int unsigned RUN_REPEAT  = 1;
   localparam int unsigned RUN_CYCLE   = 2;
   localparam int unsigned RUN_IMMED   = 3;
   localparam int unsigned RUN_WAIT    = 4;
   localparam int unsigned RUN_COUNT   = 5;

   // Register indexes; register i lies at byte address 4*i.
   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [2:0] REG_TIMEOUT  = 3'd0;
   localparam logic [2:0] REG_REPEAT   = 3'd1;
   localparam logic [2:0] REG_CYCLE    = 3'd2;
   localparam logic [2:0] REG_IMMED    = 3'd3;
   localparam logic [2:0] REG_IMM_TX   = 3'd4;
   localparam logic [2:0] REG_WAIT     = 3'd5;

   localparam int unsigned TIME_W = 16;
   localparam int unsigned TX_W   = 8;

   typedef logic [TIME_W-1:0] time_type;

   // Configuration handed from the register file to the mode machine.
   typedef struct packed {
      time_type          timeout_time;
      time_type          repeat_message_time;
      time_type          msg_cycle_time;
      time_type          immediate_cycle_time;
      logic [TX_W-1:0]   immediate_transmissions;
      time_type          wait_bus_sleep_time;
   } cfg_type;

endpackage

// ===== src/nmsm_if.sv =====
// Valid/ready channel interfaces for the request and result transfers.
// Depends on nothing but the port widths fixed for the block.
interface nmsm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic       full_com_request;

   modport source (output valid, output kind, output full_com_request, input ready);
   modport sink (input valid, input kind, input full_com_request, output ready);
endinterface

interface nmsm_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic       send_message;

   modport source (output valid, output mode, output send_message, input ready);
   modport sink (input valid, input mode, input send_message, output ready);
endinterface

// ===== src/nmsm_csr.sv =====
// APB-style configuration register file of the mode machine.
// Depends on nmsm_pkg for register indexes and the configuration struct.
module nmsm_csr
   import nmsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic [2:0] reg_index;
   logic       write_en;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   // Register writes happen in the access phase of a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (write_en) begin
         unique case (reg_index)
            REG_TIMEOUT: cfg_ff.timeout_time            <= csr_pwdata[TIME_W-1:0];
            REG_REPEAT:  cfg_ff.repeat_message_time     <= csr_pwdata[TIME_W-1:0];
            REG_CYCLE:   cfg_ff.msg_cycle_time          <= csr_pwdata[TIME_W-1:0];
            REG_IMMED:   cfg_ff.immediate_cycle_time    <= csr_pwdata[TIME_W-1:0];
            REG_IMM_TX:  cfg_ff.immediate_transmissions <= csr_pwdata[TX_W-1:0];
            REG_WAIT:    cfg_ff.wait_bus_sleep_time     <= csr_pwdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // Read-back multiplexer.
   always_comb begin
      unique case (reg_index)
         REG_TIMEOUT: csr_prdata = {16'd0, cfg_ff.timeout_time};
         REG_REPEAT:  csr_prdata = {16'd0, cfg_ff.repeat_message_time};
         REG_CYCLE:   csr_prdata = {16'd0, cfg_ff.msg_cycle_time};
         REG_IMMED:   csr_prdata = {16'd0, cfg_ff.immediate_cycle_time};
         REG_IMM_TX:  csr_prdata = {24'd0, cfg_ff.immediate_transmissions};
         REG_WAIT:    csr_prdata = {16'd0, cfg_ff.wait_bus_sleep_time};
         default:     csr_prdata = '0;
      endcase
   end

endmodule

// ===== src/nmsm_core.sv =====
// Mode machine with its timers and the registered result stage.
// Depends on nmsm_pkg and on the channel interfaces in nmsm_if.sv.
module nmsm_core
   import nmsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   nmsm_req_if.sink    req_if,
   nmsm_rsp_if.source  rsp_if
);

   logic [2:0]           mode_ff, mode_in;
   logic [RUN_COUNT-1:0] run_ff, run_in;
   time_type             timeout_cnt_ff, timeout_cnt_in;
   time_type             repeat_cnt_ff, repeat_cnt_in;
   time_type             cycle_cnt_ff, cycle_cnt_in;
   time_type             immed_cnt_ff, immed_cnt_in;
   time_type             wait_cnt_ff, wait_cnt_in;
   logic [TX_W-1:0]      imm_left_ff, imm_left_in;
   logic                 send;
   logic                 accept;
   logic                 rsp_valid_ff;
   logic [2:0]           rsp_mode_ff;
   logic                 rsp_send_ff;

   // A new request enters whenever the result register is empty or drains now.
   assign req_if.ready = ~rsp_valid_ff | rsp_if.ready;
   assign accept       = req_if.valid & req_if.ready;

   // Next state of the mode machine for the accepted request.
   always_comb begin
      mode_in        = mode_ff;
      run_in         = run_ff;
      timeout_cnt_in = timeout_cnt_ff;
      repeat_cnt_in  = repeat_cnt_ff;
      cycle_cnt_in   = cycle_cnt_ff;
      immed_cnt_in   = immed_cnt_ff;
      wait_cnt_in    = wait_cnt_ff;
      imm_left_in    = imm_left_ff;
      send           = 1'b0;
      if (accept) begin
         unique case (req_if.kind)
            KIND_TICK: begin
               unique case (mode_ff)
                  MODE_SLEEP: begin
                     if (req_if.full_com_request) begin
                        mode_in                = MODE_REPEAT;
                        run_in[RUN_IMMED]      = 1'b1;
                        run_in[RUN_TIMEOUT]    = 1'b1;
                        timeout_cnt_in         = '0;
                        immed_cnt_in           = '0;
                        imm_left_in            = cfg.immediate_transmissions;
                     end
                  end
                  MODE_PREP: begin
                     if (req_if.full_com_request) begin
                        mode_in                = MODE_REPEAT;
                        run_in[RUN_IMMED]      = 1'b1;
                        run_in[RUN_TIMEOUT]    = 1'b1;
                        timeout_cnt_in         = '0;
                        immed_cnt_in           = '0;
                        imm_left_in            = cfg.immediate_transmissions;
                     end else if (run_ff[RUN_WAIT]) begin
                        if (wait_cnt_ff >= cfg.wait_bus_sleep_time) begin
                           mode_in          = MODE_SLEEP;
                           run_in[RUN_WAIT] = 1'b0;
                           wait_cnt_in      = '0;
                        end else begin
                           wait_cnt_in = wait_cnt_ff + 1'b1;
                        end
                     end
                  end
                  MODE_REPEAT: begin
                     if (run_ff[RUN_IMMED]) begin
                        if (imm_left_ff == '0) begin
                           run_in[RUN_IMMED]  = 1'b0;
                           run_in[RUN_REPEAT] = 1'b1;
                           run_in[RUN_CYCLE]  = 1'b1;
                           immed_cnt_in       = '0;
                           repeat_cnt_in      = '0;
                           cycle_cnt_in       = '0;
                        end else if (immed_cnt_ff >= cfg.immediate_cycle_time) begin
                           send                = 1'b1;
                           run_in[RUN_TIMEOUT] = 1'b1;
                           timeout_cnt_in      = '0;
                           imm_left_in         = imm_left_ff - 1'b1;
                           immed_cnt_in        = '0;
                        end else begin
                           immed_cnt_in = immed_cnt_ff + 1'b1;
                        end
                     end else if (run_ff[RUN_REPEAT]) begin
                        if (repeat_cnt_ff >= cfg.repeat_message_time) begin
                           run_in[RUN_REPEAT] = 1'b0;
                           repeat_cnt_in      = '0;
                           if (req_if.full_com_request) begin
                              mode_in = MODE_NORMAL;
                           end else begin
                              mode_in           = MODE_READY;
                              run_in[RUN_CYCLE] = 1'b0;
                              cycle_cnt_in      = '0;
                           end
                        end else begin
                           repeat_cnt_in = repeat_cnt_ff + 1'b1;
                           if (run_ff[RUN_CYCLE]) begin
                              if (cycle_cnt_ff >= cfg.msg_cycle_time) begin
                                 send                = 1'b1;
                                 run_in[RUN_TIMEOUT] = 1'b1;
                                 timeout_cnt_in      = '0;
                                 cycle_cnt_in        = '0;
                              end else begin
                                 cycle_cnt_in = cycle_cnt_ff + 1'b1;
                              end
                           end
                        end
                     end
                     // The timeout timer restarts on expiry in this mode.
                     if (run_in[RUN_TIMEOUT]) begin
                        if (timeout_cnt_in >= cfg.timeout_time) begin
                           timeout_cnt_in = '0;
                        end else begin
                           timeout_cnt_in = timeout_cnt_in + 1'b1;
                        end
                     end
                  end
                  MODE_NORMAL: begin
                     if (!req_if.full_com_request) begin
                        mode_in           = MODE_READY;
                        run_in[RUN_CYCLE] = 1'b0;
                        cycle_cnt_in      = '0;
                     end else if (run_ff[RUN_CYCLE]) begin
                        if (cycle_cnt_ff >= cfg.msg_cycle_time) begin
                           send                = 1'b1;
                           run_in[RUN_TIMEOUT] = 1'b1;
                           timeout_cnt_in      = '0;
                           cycle_cnt_in        = '0;
                        end else begin
                           cycle_cnt_in = cycle_cnt_ff + 1'b1;
                        end
                     end
                     if (run_in[RUN_TIMEOUT]) begin
                        if (timeout_cnt_in >= cfg.timeout_time) begin
                           timeout_cnt_in = '0;
                        end else begin
                           timeout_cnt_in = timeout_cnt_in + 1'b1;
                        end
                     end
                  end
                  MODE_READY: begin
                     if (req_if.full_com_request) begin
                        mode_in           = MODE_NORMAL;
                        run_in[RUN_CYCLE] = 1'b1;
                        cycle_cnt_in      = '0;
                     end else if (run_ff[RUN_TIMEOUT]) begin
                        if (timeout_cnt_ff >= cfg.timeout_time) begin
                           mode_in             = MODE_PREP;
                           run_in[RUN_TIMEOUT] = 1'b0;
                           timeout_cnt_in      = '0;
                           run_in[RUN_WAIT]    = 1'b1;
                           wait_cnt_in         = '0;
                        end else begin
                           timeout_cnt_in = timeout_cnt_ff + 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            KIND_START: begin
               mode_in        = MODE_SLEEP;
               run_in         = '0;
               timeout_cnt_in = '0;
               repeat_cnt_in  = '0;
               cycle_cnt_in   = '0;
               immed_cnt_in   = '0;
               wait_cnt_in    = '0;
            end
            KIND_STOP: begin
               mode_in = MODE_INIT;
            end
            default: ;
         endcase
      end
   end

   // Mode machine state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_INIT;
         run_ff         <= '0;
         timeout_cnt_ff <= '0;
         repeat_cnt_ff  <= '0;
         cycle_cnt_ff   <= '0;
         immed_cnt_ff   <= '0;
         wait_cnt_ff    <= '0;
         imm_left_ff    <= '0;
      end else begin
         mode_ff        <= mode_in;
         run_ff         <= run_in;
         timeout_cnt_ff <= timeout_cnt_in;
         repeat_cnt_ff  <= repeat_cnt_in;
         cycle_cnt_ff   <= cycle_cnt_in;
         immed_cnt_ff   <= immed_cnt_in;
         wait_cnt_ff    <= wait_cnt_in;
         imm_left_ff    <= imm_left_in;
      end
   end

   // Result register; it holds while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_mode_ff <= mode_in;
         rsp_send_ff <= send;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.mode         = rsp_mode_ff;
   assign rsp_if.send_message = rsp_send_ff;

endmodule

// ===== src/network_management_state_machine_top.sv =====
// Network-management mode machine, top level.
// Requests arrive on req_if (kind: tick, start or stop; a tick carries the
// full-communication request bit). Each request yields exactly one result on
// rsp_if: the mode after the request and a pulse that says one NM message
// goes out on this tick.
// Timing constants are written over the APB-style csr_ port; they are to be
// changed only while no request is in flight.
// A result is registered and appears in the cycle after its request transfer.
// Throughput: one request per cycle unless the receiver stalls, set by the
// single mode machine update that sits between state and result registers.
// A new request is taken while a result waits, as long as that result is
// taken in the same cycle; while the receiver stalls, the result register
// holds and req_if.ready stays low.
// Reset (synchronous) puts the machine in init mode, clears all timers and
// the immediate message count, and zeroes the configuration registers.
// Depends on nmsm_pkg, nmsm_if.sv, nmsm_csr and nmsm_core.
module network_management_state_machine_top
   import nmsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   nmsm_req_if.sink              req_if,
   nmsm_rsp_if.source            rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   // Configuration registers.
   nmsm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Mode machine and result stage.
   nmsm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // A message is sent only in repeat message or normal operation.
   a_send_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.send_message) |->
         (rsp_if.mode == MODE_REPEAT || rsp_if.mode == MODE_NORMAL))
      else $error("send pulse outside repeat or normal mode");

   // A start transfer reports bus sleep without a message in the next cycle.
   a_start_sleep: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.kind == KIND_START) |=>
         (rsp_if.valid && rsp_if.mode == MODE_SLEEP && !rsp_if.send_message))
      else $error("start did not yield bus sleep");

   // A stop transfer reports init mode in the next cycle.
   a_stop_init: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.kind == KIND_STOP) |=>
         (rsp_if.valid && rsp_if.mode == MODE_INIT && !rsp_if.send_message))
      else $error("stop did not yield init mode");

endmodule
